// File: rtl/core/sfr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stuffed frame receiver.
package sfr_pkg;

  localparam int MAX_FRAME_BYTES = 1024;
  localparam int COUNT_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int FIFO_DEPTH = 2;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE = 8'h7D;
  localparam logic [7:0] ESC_FLAG = 8'h5E;
  localparam logic [7:0] ESC_ESC = 8'h5D;
  localparam logic [7:0] CTRL_SEQ0 = 8'h00;
  localparam logic [7:0] CTRL_SEQ1 = 8'h80;
  localparam logic [7:0] RR_SEQ0 = 8'hAA;
  localparam logic [7:0] RR_SEQ1 = 8'hAB;
  localparam logic [7:0] REJ_SEQ0 = 8'h54;
  localparam logic [7:0] REJ_SEQ1 = 8'h55;
  localparam logic [7:0] ADDR_RESET = 8'h03;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(1024);

  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic close;
    logic seq;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic seq;
    logic last;
  } result_t;

endpackage

// File: rtl/core/sfr_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces: line byte input, result output, config write.
interface sfr_byte_if;
  logic valid;
  logic ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic seq;
  logic last;
  modport source (output valid, output kind, output value, output seq, output last,
                  input ready);
  modport sink (input valid, input kind, input value, input seq, input last,
                output ready);
endinterface

interface sfr_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/sfr_fifo.sv
`timescale 1ns / 1ps
// Short op queue between the front and back parts.
module sfr_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfr_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output sfr_pkg::op_t  pop_op
);
  import sfr_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  op_t entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CNT_W'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("op pushed into full queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

// File: rtl/core/sfr_front.sv
`timescale 1ns / 1ps
// Front part: header hunt and destuffing, turns line bytes into ops.
module sfr_front (
  input  logic          clk,
  input  logic          rst,
  sfr_byte_if.sink      rx,
  input  logic [7:0]    address_byte,
  input  logic          queue_full,
  output logic          push,
  output sfr_pkg::op_t  push_op
);
  import sfr_pkg::*;

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_FLAG = 3'd1;
  localparam logic [2:0] PH_ADDR = 3'd2;
  localparam logic [2:0] PH_CTRL = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic escape_pending;
  logic escape_next;
  logic seq_bit;
  logic seq_next;
  logic accept;
  logic [7:0] b;
  logic [7:0] hdr_check;

  assign rx.ready = !queue_full;
  assign accept = rx.valid && !queue_full;
  assign b = rx.rx_byte;
  assign hdr_check = address_byte ^ (seq_bit ? CTRL_SEQ1 : CTRL_SEQ0);

  always_comb begin
    phase_next = phase;
    escape_next = escape_pending;
    seq_next = seq_bit;
    push = 1'b0;
    push_op.close = 1'b0;
    push_op.seq = seq_bit;
    push_op.data = b;
    if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (b == FLAG_BYTE) phase_next = PH_FLAG;
        end
        PH_FLAG: begin
          if (b == FLAG_BYTE) phase_next = PH_FLAG;
          else if (b == address_byte) phase_next = PH_ADDR;
          else phase_next = PH_HUNT;
        end
        PH_ADDR: begin
          if (b == CTRL_SEQ0 || b == CTRL_SEQ1) begin
            seq_next = (b == CTRL_SEQ1);
            phase_next = PH_CTRL;
          end else if (b == FLAG_BYTE) begin
            phase_next = PH_FLAG;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_CTRL: begin
          if (b == hdr_check) begin
            escape_next = 1'b0;
            phase_next = PH_DATA;
          end else if (b == FLAG_BYTE) begin
            phase_next = PH_FLAG;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (b == FLAG_BYTE) begin
            push = 1'b1;
            push_op.close = 1'b1;
            escape_next = 1'b0;
            phase_next = PH_FLAG;
          end else if (escape_pending) begin
            escape_next = 1'b0;
            if (b == ESC_FLAG) begin
              push = 1'b1;
              push_op.data = FLAG_BYTE;
            end else if (b == ESC_ESC) begin
              push = 1'b1;
              push_op.data = ESC_BYTE;
            end
          end else if (b == ESC_BYTE) begin
            escape_next = 1'b1;
          end else begin
            push = 1'b1;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      escape_pending <= 1'b0;
      seq_bit <= 1'b0;
    end else begin
      phase <= phase_next;
      escape_pending <= escape_next;
      seq_bit <= seq_next;
    end
  end

  a_escape_in_data: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> phase == PH_DATA)
    else $error("escape pending outside payload");
  a_close_returns_flag: assert property (@(posedge clk) disable iff (rst)
    push && push_op.close |=> phase == PH_FLAG && !escape_pending)
    else $error("closing flag did not return to flag-seen");

endmodule

// File: rtl/core/sfr_back.sv
`timescale 1ns / 1ps
// Back part: byte counting, check tracking, delayed payload and verdicts.
module sfr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        op_valid,
  input  sfr_pkg::op_t                op,
  output logic                        pop,
  input  logic [sfr_pkg::COUNT_W-1:0] length_limit,
  sfr_result_if.source                res
);
  import sfr_pkg::*;

  localparam logic [COUNT_W:0] MAX_LIMIT = (COUNT_W + 1)'(MAX_FRAME_BYTES);

  logic [7:0] held_byte;
  logic held_valid;
  logic [7:0] running_check;
  logic [COUNT_W-1:0] byte_count;
  logic too_long;
  logic out_valid;
  result_t out_reg;
  logic [COUNT_W:0] limit_now;
  logic [COUNT_W:0] count_inc;
  logic over;

  assign pop = op_valid && (!out_valid || res.ready);
  assign limit_now = ({1'b0, length_limit} > MAX_LIMIT) ? MAX_LIMIT : {1'b0, length_limit};
  assign count_inc = {1'b0, byte_count} + 1'b1;
  assign over = count_inc > limit_now;

  assign res.valid = out_valid;
  assign res.kind = out_reg.kind;
  assign res.value = out_reg.value;
  assign res.seq = out_reg.seq;
  assign res.last = out_reg.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte <= '0;
      held_valid <= 1'b0;
      running_check <= '0;
      byte_count <= '0;
      too_long <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready) out_valid <= 1'b0;
      if (pop) begin
        if (op.close) begin
          out_valid <= 1'b1;
          out_reg.seq <= op.seq;
          out_reg.last <= 1'b1;
          if (too_long || byte_count == '0 || !held_valid) begin
            out_reg.kind <= KIND_ERROR;
            out_reg.value <= '0;
          end else if (held_byte == running_check) begin
            out_reg.kind <= KIND_ACCEPT;
            out_reg.value <= op.seq ? RR_SEQ0 : RR_SEQ1;
          end else begin
            out_reg.kind <= KIND_REJECT;
            out_reg.value <= op.seq ? REJ_SEQ1 : REJ_SEQ0;
          end
          held_byte <= '0;
          held_valid <= 1'b0;
          running_check <= '0;
          byte_count <= '0;
          too_long <= 1'b0;
        end else if (!too_long) begin
          if (over) begin
            too_long <= 1'b1;
          end else begin
            byte_count <= count_inc[COUNT_W-1:0];
            if (held_valid) begin
              out_valid <= 1'b1;
              out_reg.kind <= KIND_DATA;
              out_reg.value <= held_byte;
              out_reg.seq <= op.seq;
              out_reg.last <= 1'b0;
              running_check <= running_check ^ held_byte;
            end
            held_byte <= op.data;
            held_valid <= 1'b1;
          end
        end
      end
    end
  end

  a_held_counted: assert property (@(posedge clk) disable iff (rst)
    held_valid == (byte_count != '0))
    else $error("held byte and count disagree");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, byte_count} <= MAX_LIMIT)
    else $error("byte count past frame limit");

endmodule

// File: rtl/core/stuffed_frame_receiver_top.sv
`timescale 1ns / 1ps
// Top level of the stuffed frame receiver.
//
//  channel  dir  word                                  handshake
//  rx       in   rx_byte[7:0]                          valid/ready
//  res      out  kind[1:0] value[7:0] seq last         valid/ready
//  cfg      in   index[1:0] data[10:0]                 valid/ready (ready always high)
//
// One line byte per clock while rx.ready is high; payload goes via queue and held byte.
// The two-entry op queue and result register let rx keep flowing while res stalls.
// rx.ready drops only when the op queue is full.
// Synchronous active-high reset: hunting for flag, address 0x03, limit 1024.
module stuffed_frame_receiver_top (
  input  logic       clk,
  input  logic       rst,
  sfr_byte_if.sink   rx,
  sfr_result_if.source res,
  sfr_cfg_if.sink    cfg
);
  import sfr_pkg::*;

  logic [7:0] address_byte;
  logic [COUNT_W-1:0] length_limit;
  logic push;
  op_t push_op;
  logic full;
  logic pop;
  logic empty;
  op_t pop_op;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte <= ADDR_RESET;
      length_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ADDRESS: address_byte <= cfg.data[7:0];
        REG_LIMIT: length_limit <= cfg.data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sfr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .rx           (rx),
    .address_byte (address_byte),
    .queue_full   (full),
    .push         (push),
    .push_op      (push_op)
  );

  sfr_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .pop_op  (pop_op)
  );

  sfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (!empty),
    .op           (pop_op),
    .pop          (pop),
    .length_limit (length_limit),
    .res          (res)
  );

endmodule
